FILE: rtl/i2cmbe_pkg.sv
package i2cmbe_pkg;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ST_C   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SP_A   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SP_B   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_SP_C   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_B_SET  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_B_RISE = 4'd8;
  localparam logic [PHASE_W-1:0] PH_B_FALL = 4'd9;
  localparam logic [PHASE_W-1:0] PH_FINISH = 4'd10;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_SETUP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SETUP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SETUP  = 3'd5;

  localparam logic [3:0] LAST_DATA_BIT = 4'd7;
  localparam logic [3:0] ACK_SLOT      = 4'd8;

  // input item tdata, highest bit first
  typedef struct packed {
    logic [4:0] pad;
    logic       sda_sample;
    logic       send_ack;
    logic [7:0] tx_byte;
    logic       cmd_valid;
  } cmd_item_t;

  // result item tdata, highest bit first
  typedef struct packed {
    logic [1:0] pad;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

FILE: rtl/i2c_master_byte_engine.sv
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle unless the output stalls; each item is one bus tick, worked out by
// the phase sequencer between the input handshake and the output register.
// s_axis_tready stays high unless a result is held and not taken.
// Reset (synchronous, active high): engine idle, SCL/SDA high and driven,
// timing registers back to their defaults, no result pending.
module i2c_master_byte_engine
  import i2cmbe_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // cmd_valid[0], tx_byte[8:1], send_ack[9], sda_sample[10], zeros above
  input  logic [15:0]          s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // rx_byte[12:5], ack_seen[13], zeros above
  output logic [15:0]          m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int unsigned CW = (DELAY_WIDTH < REG_W) ? DELAY_WIDTH : REG_W;

  logic [REG_W-1:0] start_setup_ticks, start_hold_ticks, data_hold_ticks;
  logic [REG_W-1:0] data_setup_ticks, clock_high_ticks, stop_setup_ticks;

  logic [PHASE_W-1:0]     phase, phase_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [DELAY_WIDTH-1:0] wait_count, wait_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [1:0]             current_command, current_command_next;
  logic                   ack_choice, ack_choice_next;
  logic                   scl_reg, scl_reg_next;
  logic                   sda_reg, sda_reg_next;
  logic                   sda_dir_reg, sda_dir_reg_next;
  logic                   ack_reg, ack_reg_next;
  logic [7:0]             rx_hold, rx_hold_next;
  logic                   done_next;

  cmd_item_t in_item;
  result_t   res;
  logic      in_fire;

  assign in_item       = cmd_item_t'(s_axis_tdata);
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  function automatic logic [DELAY_WIDTH-1:0] delay_of(input logic [REG_W-1:0] r);
    return DELAY_WIDTH'(r[CW-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      start_setup_ticks <= 16'd5;
      start_hold_ticks  <= 16'd4;
      data_hold_ticks   <= 16'd1;
      data_setup_ticks  <= 16'd1;
      clock_high_ticks  <= 16'd5;
      stop_setup_ticks  <= 16'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_SETUP: start_setup_ticks <= cfg_data;
        REG_START_HOLD:  start_hold_ticks  <= cfg_data;
        REG_DATA_HOLD:   data_hold_ticks   <= cfg_data;
        REG_DATA_SETUP:  data_setup_ticks  <= cfg_data;
        REG_CLOCK_HIGH:  clock_high_ticks  <= cfg_data;
        REG_STOP_SETUP:  stop_setup_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                run_step;
    logic [PHASE_W-1:0]  ph;
    logic                rd;
    phase_next           = phase;
    bit_count_next       = bit_count;
    wait_count_next      = wait_count;
    shift_byte_next      = shift_byte;
    current_command_next = current_command;
    ack_choice_next      = ack_choice;
    scl_reg_next         = scl_reg;
    sda_reg_next         = sda_reg;
    sda_dir_reg_next     = sda_dir_reg;
    ack_reg_next         = ack_reg;
    rx_hold_next         = rx_hold;
    done_next            = 1'b0;
    run_step             = 1'b0;
    ph                   = phase;

    if (phase == PH_IDLE || phase > PH_FINISH) begin
      phase_next = PH_IDLE;
      ph         = PH_IDLE;
      if (in_item.cmd_valid) begin
        // take the command and make its first pin step on this tick
        current_command_next = s_axis_tuser;
        ack_choice_next      = in_item.send_ack;
        bit_count_next       = '0;
        wait_count_next      = '0;
        shift_byte_next      = (s_axis_tuser == CMD_WRITE) ? in_item.tx_byte : 8'd0;
        case (s_axis_tuser)
          CMD_START: ph = PH_ST_A;
          CMD_STOP:  ph = PH_SP_A;
          default:   ph = PH_B_SET;
        endcase
        run_step = 1'b1;
      end
    end else if (wait_count != '0) begin
      wait_count_next = wait_count - 1'b1;
    end else begin
      run_step = 1'b1;
    end

    rd = (current_command_next == CMD_READ);

    if (run_step) begin
      case (ph)
        PH_ST_A: begin
          sda_dir_reg_next = 1'b1;
          sda_reg_next     = 1'b1;
          scl_reg_next     = 1'b1;
          wait_count_next  = delay_of(start_setup_ticks);
          phase_next       = PH_ST_B;
        end
        PH_ST_B: begin
          sda_reg_next    = 1'b0;
          wait_count_next = delay_of(start_hold_ticks);
          phase_next      = PH_ST_C;
        end
        PH_ST_C: begin
          scl_reg_next    = 1'b0;
          wait_count_next = delay_of(data_hold_ticks);
          phase_next      = PH_FINISH;
        end
        PH_SP_A: begin
          sda_dir_reg_next = 1'b1;
          sda_reg_next     = 1'b0;
          wait_count_next  = delay_of(data_setup_ticks);
          phase_next       = PH_SP_B;
        end
        PH_SP_B: begin
          scl_reg_next    = 1'b1;
          wait_count_next = delay_of(stop_setup_ticks);
          phase_next      = PH_SP_C;
        end
        PH_SP_C: begin
          sda_reg_next    = 1'b1;
          wait_count_next = '0;
          phase_next      = PH_FINISH;
        end
        PH_B_SET: begin
          if (bit_count_next < ACK_SLOT) begin
            if (rd) begin
              sda_dir_reg_next = 1'b0;
            end else begin
              sda_dir_reg_next = 1'b1;
              sda_reg_next     = shift_byte_next[7];
            end
          end else begin
            // ack slot: read drives ACK/NACK, write releases SDA for the slave
            if (rd) begin
              sda_dir_reg_next = 1'b1;
              sda_reg_next     = !ack_choice_next;
            end else begin
              sda_dir_reg_next = 1'b0;
            end
          end
          wait_count_next = delay_of(data_setup_ticks);
          phase_next      = PH_B_RISE;
        end
        PH_B_RISE: begin
          scl_reg_next    = 1'b1;
          wait_count_next = delay_of(clock_high_ticks);
          phase_next      = PH_B_FALL;
        end
        PH_B_FALL: begin
          if (bit_count < ACK_SLOT) begin
            if (rd) begin
              shift_byte_next = {shift_byte[6:0], in_item.sda_sample};
            end else begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
            end
            if (rd && bit_count == LAST_DATA_BIT) begin
              rx_hold_next = {shift_byte[6:0], in_item.sda_sample};
            end
          end else if (!rd) begin
            ack_reg_next = !in_item.sda_sample;
          end
          scl_reg_next    = 1'b0;
          wait_count_next = delay_of(data_hold_ticks);
          if (bit_count >= ACK_SLOT) begin
            phase_next = PH_FINISH;
          end else begin
            bit_count_next = bit_count + 1'b1;
            phase_next     = PH_B_SET;
          end
        end
        PH_FINISH: begin
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res           = '0;
    res.scl_level = scl_reg_next;
    res.sda_level = sda_reg_next;
    res.sda_drive = sda_dir_reg_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done_next;
    res.rx_byte   = rx_hold_next;
    res.ack_seen  = ack_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= '0;
      wait_count      <= '0;
      shift_byte      <= '0;
      current_command <= CMD_START;
      ack_choice      <= 1'b0;
      scl_reg         <= 1'b1;
      sda_reg         <= 1'b1;
      sda_dir_reg     <= 1'b1;
      ack_reg         <= 1'b0;
      rx_hold         <= '0;
    end else if (in_fire) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      wait_count      <= wait_count_next;
      shift_byte      <= shift_byte_next;
      current_command <= current_command_next;
      ack_choice      <= ack_choice_next;
      scl_reg         <= scl_reg_next;
      sda_reg         <= sda_reg_next;
      sda_dir_reg     <= sda_dir_reg_next;
      ack_reg         <= ack_reg_next;
      rx_hold         <= rx_hold_next;
    end
  end

  // hold the result until taken; a new item may load it in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= 16'(res);
    end
  end

endmodule
